// File: hw/rtl/mtg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and word functions of the twister generator.
// ---------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned TABLE_DEPTH  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned WORD_W       = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam idx_t IDX_DEPTH    = idx_t'(TABLE_DEPTH);
  localparam idx_t IDX_LAST     = idx_t'(TABLE_DEPTH - 1);
  localparam idx_t IDX_OFFSET   = idx_t'(TWIST_OFFSET);
  localparam idx_t IDX_SPLIT    = idx_t'(TABLE_DEPTH - TWIST_OFFSET);
  localparam idx_t IDX_FAST_END = idx_t'(TWIST_OFFSET);
  localparam idx_t IDX_LAZY_ST  = idx_t'(TWIST_OFFSET + 1);
  localparam idx_t IDX_UNSEEDED = idx_t'(TABLE_DEPTH + 1);

  localparam word_t INIT_MULT    = 32'd1812433253;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;
  localparam word_t DEFAULT_SEED = 32'd5489;
  localparam word_t TWIST_MATRIX = 32'h9908b0df;

  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_RESEED = 1'b1;

  // One step of the seeding recurrence.
  function automatic word_t init_step(input word_t prev, input idx_t pos);
    word_t x;
    x = prev ^ (prev >> 30);
    return word_t'(x * INIT_MULT) + word_t'(pos);
  endfunction

  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t r;
    y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    r = (y >> 1) ^ far;
    if (nxt[0]) begin
      r = r ^ TWIST_MATRIX;
    end
    return r;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mersenne_twister_generator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 number generator with lazy seeding of a 624-word state memory.
// ---------------------------------------------------------------------------
// One word at a time. A draw passes through the accepting cycle, reads on the
// single read port of the state memory (current, next, far and the seed chain
// word), one twist and write, one lazy seeding write, the launch of the
// remainder, the radix-16 remainder unit (eight steps and its done flag) and
// the load of the output register. A draw past the lazy seeding window skips
// the seeding write, and a draw with an empty range or a span of 2^31 or more
// skips the remainder unit. A stalled receiver holds the finished word in the
// last step. A reseed writes 398 words and gives no word. The first draw after
// reset seeds all 624 words from 5489 first. The output register holds a
// finished word while the next input word is taken.
module mersenne_twister_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,  // seed_value, range_low, range_high
  input  wire logic        s_axis_tuser_i,  // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [95:0]      m_axis_tdata_o   // raw_word, half_word, coin, ranged_value
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_INIT_WR  = 9'b000000010,
    ST_INIT_MUL = 9'b000000100,
    ST_RD       = 9'b000001000,
    ST_TWIST    = 9'b000010000,
    ST_LAZY_WR  = 9'b000100000,
    ST_RANGE    = 9'b001000000,
    ST_DIV      = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  mtg_pkg::idx_t  read_q, read_d, init_q, init_d, k_q, k_d;
  mtg_pkg::idx_t  pos_q, pos_d, last_q, last_d;
  logic           full_q, full_d;
  logic [2:0]     cnt_q, cnt_d;
  mtg_pkg::word_t word_q, word_d;
  mtg_pkg::word_t cur_q, next_q, far_q, prev_q;
  mtg_pkg::word_t raw_q, raw_d;
  mtg_pkg::word_t lo_q, hi_q;
  logic [95:0]    out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic           mem_we;
  mtg_pkg::idx_t  mem_waddr, mem_raddr;
  mtg_pkg::word_t mem_wdata, mem_rdata, twisted, span, ranged;
  mtg_pkg::idx_t  next_addr, far_addr;
  logic           lazy, span_ok, in_acc, rem_start, rem_busy, rem_done;
  mtg_pkg::word_t rem_val;

  mtg_ram #(
    .WIDTH(mtg_pkg::WORD_W),
    .DEPTH(mtg_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  mtg_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(raw_q),
    .divisor_i (span),
    .busy_o    (rem_busy),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  assign next_addr = (k_q == mtg_pkg::IDX_LAST) ? '0 : k_q + 1'b1;
  assign far_addr  = (k_q < mtg_pkg::IDX_SPLIT) ? k_q + mtg_pkg::IDX_OFFSET
                                                : k_q - mtg_pkg::IDX_SPLIT;
  // Lazy seeding rides along while the twist is in the lower part.
  assign lazy      = (k_q < mtg_pkg::IDX_SPLIT) && (init_q != '0)
                     && (init_q < mtg_pkg::IDX_DEPTH);
  assign twisted   = mtg_pkg::twist(cur_q, next_q, far_q);
  assign span      = hi_q - lo_q;
  assign span_ok   = ($signed(lo_q) < $signed(hi_q)) && !span[mtg_pkg::WORD_W-1];
  assign ranged    = span_ok ? lo_q + rem_val : lo_q;
  assign rem_start = (state_q == ST_RANGE) && span_ok;

  always_comb begin
    state_d     = state_q;
    read_d      = read_q;
    init_d      = init_q;
    k_d         = k_q;
    pos_d       = pos_q;
    last_d      = last_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    raw_d       = raw_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = k_q;
    mem_wdata   = twisted;
    mem_raddr   = k_q;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pos_d = '0;
          if (s_axis_tuser_i == mtg_pkg::ACT_RESEED) begin
            word_d  = s_axis_tdata_i[31:0];
            last_d  = mtg_pkg::IDX_FAST_END;
            full_d  = 1'b0;
            state_d = ST_INIT_WR;
          end else if (read_q > mtg_pkg::IDX_DEPTH) begin
            word_d  = mtg_pkg::DEFAULT_SEED;
            last_d  = mtg_pkg::IDX_LAST;
            full_d  = 1'b1;
            state_d = ST_INIT_WR;
          end else begin
            k_d     = (read_q == mtg_pkg::IDX_DEPTH) ? '0 : read_q;
            cnt_d   = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_INIT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = word_q;
        if (pos_q == last_q) begin
          if (full_q) begin
            init_d  = mtg_pkg::IDX_DEPTH;
            k_d     = '0;
            cnt_d   = '0;
            state_d = ST_RD;
          end else begin
            init_d  = mtg_pkg::IDX_LAZY_ST;
            read_d  = mtg_pkg::IDX_DEPTH;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_INIT_MUL;
        end
      end
      ST_INIT_MUL: begin
        pos_d   = pos_q + 1'b1;
        word_d  = mtg_pkg::init_step(word_q, pos_q + 1'b1);
        state_d = ST_INIT_WR;
      end
      ST_RD: begin
        case (cnt_q)
          3'd0:    mem_raddr = k_q;
          3'd1:    mem_raddr = next_addr;
          3'd2:    mem_raddr = far_addr;
          default: mem_raddr = init_q - 1'b1;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd4) begin
          state_d = ST_TWIST;
        end
      end
      ST_TWIST: begin
        mem_we  = 1'b1;
        raw_d   = mtg_pkg::temper(twisted);
        read_d  = k_q + 1'b1;
        state_d = lazy ? ST_LAZY_WR : ST_RANGE;
      end
      ST_LAZY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = mtg_pkg::init_step(prev_q, init_q);
        init_d    = init_q + 1'b1;
        state_d   = ST_RANGE;
      end
      ST_RANGE: begin
        state_d = span_ok ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (rem_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = {ranged, raw_q[27], raw_q[31:1], raw_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      read_q      <= mtg_pkg::IDX_UNSEEDED;
      init_q      <= mtg_pkg::IDX_DEPTH;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      read_q      <= read_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    full_q <= full_d;
    word_q <= word_d;
    raw_q  <= raw_d;
    out_q  <= out_d;
    if (in_acc) begin
      lo_q <= s_axis_tdata_i[63:32];
      hi_q <= s_axis_tdata_i[95:64];
    end
    // Read data arrives in the cycle after its address was issued.
    if (state_q == ST_RD) begin
      case (cnt_q)
        3'd1:    cur_q  <= mem_rdata;
        3'd2:    next_q <= mem_rdata;
        3'd3:    far_q  <= mem_rdata;
        3'd4:    prev_q <= mem_rdata;
        default: ;
      endcase
    end
  end

  a_lazy_not_twisted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAZY_WR) |-> (init_q != k_q))
    else $error("lazy seeding overwrites the twisted word");
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_q <= mtg_pkg::IDX_UNSEEDED) && (init_q <= mtg_pkg::IDX_DEPTH))
    else $error("table index out of range");
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!out_valid_q || m_axis_tready_i)) |=> m_axis_tvalid_o)
    else $error("finished word not presented");
  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !rem_busy)
    else $error("input taken while remainder still running");

endmodule
`default_nettype wire

// File: hw/rtl/mtg_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mtg_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/mtg_rem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mtg_rem
// Iterative unsigned remainder, four restoring steps per cycle.
// ---------------------------------------------------------------------------
module mtg_rem (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  mtg_pkg::word_t     dividend_i,
  input  mtg_pkg::word_t     divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output mtg_pkg::word_t     rem_o
);

  localparam int unsigned STEPS = 4;
  localparam int unsigned CYC   = mtg_pkg::WORD_W / STEPS;
  localparam int unsigned CNT_W = $clog2(CYC);

  mtg_pkg::word_t   rem_q, rem_d;
  mtg_pkg::word_t   dvd_q, dvd_d;
  mtg_pkg::word_t   div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    logic [mtg_pkg::WORD_W:0] t;
    rem_d = rem_q;
    for (int j = 0; j < STEPS; j++) begin
      t = {rem_d, dvd_q[mtg_pkg::WORD_W-1-j]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[mtg_pkg::WORD_W-1:0];
    end
    dvd_d = dvd_q << STEPS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CYC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && div_q != '0) |-> (rem_q < div_q))
    else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("done without a running division");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done while still busy");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the twister generator against a cycle-free model of its table.
// Reseed and draw words go in through a bursty sender and results come out
// through a stalling receiver. Each result is compared field by field with
// the oldest predicted word.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        action;
    logic [31:0] seed_value;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } gen_req_t;

  // Listed from the highest bits down so that raw_word sits in the lowest bits.
  typedef struct packed {
    logic [31:0] ranged_value;
    logic        coin;
    logic [30:0] half_word;
    logic [31:0] raw_word;
  } gen_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;

  mersenne_twister_generator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  gen_req_t  pending_reqs[$];
  gen_word_t expected_words[$];
  int        fail_count = 0;
  int        draws_sent = 0;
  int        reseeds_sent = 0;
  int        words_checked = 0;
  bit        hold_sender = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  longint    cycle_count = 0;

  // Predictor state of the generator.
  mtg_pkg::word_t pred_table[mtg_pkg::TABLE_DEPTH];
  int             pred_read = mtg_pkg::TABLE_DEPTH + 1;
  int             pred_init = mtg_pkg::TABLE_DEPTH;

  function automatic mtg_pkg::word_t seed_step(mtg_pkg::word_t prev, int pos);
    return (prev ^ (prev >> 30)) * 32'd1812433253 + mtg_pkg::word_t'(pos);
  endfunction

  function automatic mtg_pkg::word_t twist_step(mtg_pkg::word_t cur, mtg_pkg::word_t nxt,
                                                mtg_pkg::word_t far);
    mtg_pkg::word_t r;
    r = ({cur[31], nxt[30:0]} >> 1) ^ far;
    if (nxt[0]) r = r ^ 32'h9908b0df;
    return r;
  endfunction

  function automatic mtg_pkg::word_t temper_step(mtg_pkg::word_t w);
    mtg_pkg::word_t y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    return y ^ (y >> 18);
  endfunction

  task automatic predict_request(gen_req_t req);
    int             k;
    mtg_pkg::word_t w;
    mtg_pkg::word_t span;
    gen_word_t      res;
    if (req.action == mtg_pkg::ACT_RESEED) begin
      pred_table[0] = req.seed_value;
      for (int i = 1; i <= mtg_pkg::TWIST_OFFSET; i++)
        pred_table[i] = seed_step(pred_table[i-1], i);
      pred_init = mtg_pkg::TWIST_OFFSET + 1;
      pred_read = mtg_pkg::TABLE_DEPTH;
      return;
    end
    if (pred_read == mtg_pkg::TABLE_DEPTH) begin
      pred_read = 0;
    end else if (pred_read > mtg_pkg::TABLE_DEPTH) begin
      // Unseeded: the whole table is seeded from the default first.
      pred_table[0] = 32'd5489;
      for (int i = 1; i < mtg_pkg::TABLE_DEPTH; i++)
        pred_table[i] = seed_step(pred_table[i-1], i);
      pred_init = mtg_pkg::TABLE_DEPTH;
      pred_read = 0;
    end
    k = pred_read;
    if (k == mtg_pkg::TABLE_DEPTH - 1) begin
      pred_table[k] = twist_step(pred_table[k], pred_table[0],
                                 pred_table[mtg_pkg::TWIST_OFFSET-1]);
    end else if (k >= mtg_pkg::TABLE_DEPTH - mtg_pkg::TWIST_OFFSET) begin
      pred_table[k] = twist_step(pred_table[k], pred_table[k+1],
                          pred_table[k-(mtg_pkg::TABLE_DEPTH-mtg_pkg::TWIST_OFFSET)]);
    end else begin
      pred_table[k] = twist_step(pred_table[k], pred_table[k+1],
                                 pred_table[k+mtg_pkg::TWIST_OFFSET]);
      if (pred_init >= 1 && pred_init < mtg_pkg::TABLE_DEPTH) begin
        pred_table[pred_init] = seed_step(pred_table[pred_init-1], pred_init);
        pred_init++;
      end
    end
    pred_read = k + 1;
    w = temper_step(pred_table[k]);
    span = req.range_high - req.range_low;
    res.raw_word = w;
    res.half_word = w[31:1];
    res.coin = w[27];
    if ($signed(req.range_low) < $signed(req.range_high) && span != 0 && !span[31])
      res.ranged_value = req.range_low + (w % span);
    else
      res.ranged_value = req.range_low;
    expected_words.push_back(res);
  endtask

  function automatic gen_req_t make_draw(logic [31:0] lo, logic [31:0] hi);
    gen_req_t r;
    r.action = mtg_pkg::ACT_DRAW;
    r.seed_value = $urandom;
    r.range_low = lo;
    r.range_high = hi;
    return r;
  endfunction

  function automatic gen_req_t make_reseed(logic [31:0] seed);
    gen_req_t r;
    r.action = mtg_pkg::ACT_RESEED;
    r.seed_value = seed;
    r.range_low = $urandom;
    r.range_high = $urandom;
    return r;
  endfunction

  function automatic gen_req_t random_draw();
    logic [31:0] lo;
    logic [31:0] hi;
    case ($urandom_range(0, 5))
      0: begin lo = 0; hi = $urandom_range(1, 100); end
      1: begin lo = $urandom; hi = $urandom; end
      2: begin lo = 32'h80000000; hi = 32'h7fffffff; end
      3: begin lo = $urandom_range(0, 1000) - 500; hi = lo + $urandom_range(0, 2000); end
      4: begin lo = 0; hi = $urandom; end
      default: begin lo = $urandom; hi = lo; end
    endcase
    return make_draw(lo, hi);
  endfunction

  // Sender: bursts of words with random gaps.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_request(pending_reqs.pop_front());
        if (s_axis_tuser_i == mtg_pkg::ACT_RESEED) reseeds_sent++;
        else draws_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          s_axis_tvalid_i <= 1'b1;
          {s_axis_tuser_i, s_axis_tdata_i} <= {pending_reqs[0].action,
              pending_reqs[0].range_high, pending_reqs[0].range_low,
              pending_reqs[0].seed_value};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern, then compare against the oldest prediction.
  always @(posedge clk_i) begin
    gen_word_t got;
    gen_word_t exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (expected_words.size() == 0) begin
          $error("unexpected word: %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (got.raw_word !== exp_w.raw_word) begin
            $error("raw_word expected %h got %h", exp_w.raw_word, got.raw_word);
            fail_count++;
          end
          if (got.half_word !== exp_w.half_word) begin
            $error("half_word expected %h got %h", exp_w.half_word, got.half_word);
            fail_count++;
          end
          if (got.coin !== exp_w.coin) begin
            $error("coin expected %b got %b", exp_w.coin, got.coin);
            fail_count++;
          end
          if (got.ranged_value !== exp_w.ranged_value) begin
            $error("ranged_value expected %h got %h", exp_w.ranged_value,
                   got.ranged_value);
            fail_count++;
          end
        end
      end
      case ((cycle_count / 400) % 3)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i <= (cycle_count[4:2] != 3'd5) && $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 64'd3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    // Draws before any seed take the default-seed path.
    pending_reqs.push_back(make_draw(0, 32'hffffffff));
    pending_reqs.push_back(make_draw(32'h80000000, 32'h7fffffff));
    pending_reqs.push_back(make_draw(32'h7fffffff, 32'h80000000));
    pending_reqs.push_back(make_draw(5, 5));
    pending_reqs.push_back(make_draw(0, 1));
    pending_reqs.push_back(make_draw(32'hc0000000, 32'h3fffffff));
    pending_reqs.push_back(make_reseed(32'h0));
    pending_reqs.push_back(make_draw(0, 32'h7fffffff));
    pending_reqs.push_back(make_draw(32'hffffffff, 0));
    pending_reqs.push_back(make_reseed(32'hffffffff));
    pending_reqs.push_back(make_draw(0, 10));
    pending_reqs.push_back(make_reseed(32'h5555aaaa));
    pending_reqs.push_back(make_reseed(32'haaaa5555));
    pending_reqs.push_back(make_draw(32'h80000000, 32'h80000001));
    pending_reqs.push_back(make_draw(32'h7ffffffe, 32'h7fffffff));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_words.size() == 0 && !s_axis_tvalid_i);
    hold_sender = 1'b0;
    // Long runs of draws cross the table end; occasional reseeds land mid stream.
    n = 0;
    while (n < 1935) begin
      if ($urandom_range(0, 199) == 0) pending_reqs.push_back(make_reseed($urandom));
      else pending_reqs.push_back(random_draw());
      n++;
    end
    wait (pending_reqs.size() == 0);
    wait (expected_words.size() == 0);
    repeat (2000) @(posedge clk_i);
    $display("Checked %0d words from %0d draws and %0d reseeds.", words_checked,
             draws_sent, reseeds_sent);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
